>>> src/rth_pkg.sv
`timescale 1ns / 1ps

package rth_pkg;

    // Hue scale: 1/64 degree per unit, so 60 degrees is 3840.
    localparam int unsigned HUE_W      = 15;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned DIVIDEND_W = 20;  // |num| * 3840 <= 979200
    localparam int unsigned QUO_W      = 12;  // quotient never exceeds 3840

    localparam logic [HUE_W-1:0] HUE_SIXTY = 15'd3840;
    localparam logic [HUE_W-1:0] HUE_FULL  = 15'd23040;

    // Sector codes, chosen by the channel holding the maximum.
    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    // Payload handed from cell to cell along the divider chain.
    typedef struct packed {
        logic                  gray;
        logic                  neg;
        logic [1:0]            sector;
        logic [CHAN_W-1:0]     delta;
        logic [DIVIDEND_W-1:0] rem;
        logic [QUO_W-1:0]      quo;
    } t_stage;

endpackage

>>> src/rth_front.sv
`timescale 1ns / 1ps

module rth_front
    import rth_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CHAN_W-1:0] i_red,
    input  logic [CHAN_W-1:0] i_green,
    input  logic [CHAN_W-1:0] i_blue,
    output logic              o_valid,
    input  logic              i_ready,
    output t_stage            o_data
);

    logic   r_valid;
    t_stage r_data;
    t_stage n_data;

    always_comb begin
        logic [CHAN_W-1:0] hi;
        logic [CHAN_W-1:0] lo;
        logic [1:0]        sel;
        logic [CHAN_W:0]   num;
        logic [CHAN_W-1:0] mag;

        hi  = i_red;
        sel = SEC_RED;
        if (i_green > hi) begin
            hi  = i_green;
            sel = SEC_GREEN;
        end
        if (i_blue > hi) begin
            hi  = i_blue;
            sel = SEC_BLUE;
        end
        lo = i_red;
        if (i_green < lo) lo = i_green;
        if (i_blue < lo)  lo = i_blue;

        unique case (sel)
            SEC_GREEN: num = {1'b0, i_blue}  - {1'b0, i_red};
            SEC_BLUE:  num = {1'b0, i_red}   - {1'b0, i_green};
            default:   num = {1'b0, i_green} - {1'b0, i_blue};
        endcase
        mag = num[CHAN_W] ? CHAN_W'(-num) : num[CHAN_W-1:0];

        n_data.gray   = (hi == lo);
        n_data.neg    = num[CHAN_W];
        n_data.sector = sel;
        n_data.delta  = hi - lo;
        // mag * 3840 as (mag << 12) - (mag << 8)
        n_data.rem    = (DIVIDEND_W'(mag) << 12) - (DIVIDEND_W'(mag) << 8);
        n_data.quo    = '0;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> src/rth_div_cell.sv
`timescale 1ns / 1ps

module rth_div_cell
    import rth_pkg::*;
#(
    parameter int unsigned BIT = 0
)
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_stage i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_stage o_data
);

    logic   r_valid;
    t_stage r_data;
    t_stage n_data;
    logic [DIVIDEND_W-1:0] shifted;

    // One restoring step: try to take delta * 2^BIT out of the remainder.
    assign shifted = DIVIDEND_W'(i_data.delta) << BIT;

    always_comb begin
        n_data = i_data;
        if (i_data.rem >= shifted) begin
            n_data.rem      = i_data.rem - shifted;
            n_data.quo[BIT] = 1'b1;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> src/rth_back.sv
`timescale 1ns / 1ps

module rth_back
    import rth_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_stage           i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [HUE_W-1:0] o_hue
);

    logic             r_valid;
    logic [HUE_W-1:0] r_hue;
    logic [HUE_W-1:0] n_hue;

    always_comb begin
        logic [HUE_W-1:0] base;
        logic [HUE_W-1:0] q;

        q = HUE_W'(i_data.quo);
        unique case (i_data.sector)
            SEC_GREEN: base = HUE_SIXTY << 1;
            SEC_BLUE:  base = HUE_SIXTY << 2;
            default:   base = '0;
        endcase

        if (i_data.gray) begin
            n_hue = '0;
        end else if (!i_data.neg) begin
            n_hue = base + q;
        end else if (base != '0) begin
            n_hue = base - q;
        end else if (q == '0) begin
            n_hue = '0;
        end else begin
            // Negative hue in the red sector wraps round by a full turn.
            n_hue = HUE_FULL - q;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_hue <= n_hue;
        end
    end

    assign o_valid = r_valid;
    assign o_hue   = r_hue;

endmodule

>>> src/rgb_to_hue.sv
`timescale 1ns / 1ps

// RGB to hue converter. Each request on the slave stream carries one 8-bit RGB
// pixel; each request on the master stream carries its hue in units of 1/64
// degree (0 to 23039), with gray pixels giving 0. The block takes one pixel
// per clock while the master side is not stalled: the max/min/sector stage
// works in the cycle of acceptance and is registered at that edge, then the
// pixel passes through the chain of divider cells (one quotient bit per cell,
// so twelve cells for quotients up to 3840) and the output register. Every
// stage holds its own valid bit and loads whenever it is empty or the stage
// after it is empty or moving, so a stall on the master side fills the empty
// stages before the slave side is held off, and bubbles close up. There are no
// registers to set up and no state between pixels.
module rgb_to_hue
    import rth_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [14:0] hue, [15] zero
);

    // Handshake and payload between neighbouring stages: index 0 is the
    // front stage, index k+1 the output of the divider cell for bit 11-k.
    logic   valid [QUO_W+1];
    logic   ready [QUO_W+1];
    t_stage data  [QUO_W+1];

    logic [HUE_W-1:0] hue;

    rth_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_red   (i_s_axis_tdata[7:0]),
        .i_green (i_s_axis_tdata[15:8]),
        .i_blue  (i_s_axis_tdata[23:16]),
        .o_valid (valid[0]),
        .i_ready (ready[0]),
        .o_data  (data[0])
    );

    // The quotient is built from its top bit down, one bit per cell.
    for (genvar k = 0; k < QUO_W; k++) begin : g_cell
        rth_div_cell #(
            .BIT (QUO_W - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[k]),
            .o_ready (ready[k]),
            .i_data  (data[k]),
            .o_valid (valid[k+1]),
            .i_ready (ready[k+1]),
            .o_data  (data[k+1])
        );
    end

    // Sector offset, sign and wrap-around are applied in the output stage.
    rth_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (valid[QUO_W]),
        .o_ready (ready[QUO_W]),
        .i_data  (data[QUO_W]),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_hue   (hue)
    );

    assign o_m_axis_tdata = {1'b0, hue};

endmodule

>>> src/rth_checker.sv
`timescale 1ns / 1ps

module rth_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata
);

    // A stalled result request must hold its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // Hue stays below a full turn.
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[14:0] < 15'd23040)
            && !o_m_axis_tdata[15])
        else $error("hue out of range");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result offered straight after reset");

    // An empty pipeline never holds off the slave side.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_s_axis_tvalid) && !$past(i_s_axis_tvalid, 2) && !o_m_axis_tvalid
            && $past(i_rst_n) |-> o_s_axis_tready)
        else $error("input held off with an idle output");

endmodule

bind rgb_to_hue rth_checker u_rth_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

>>> bench/rgb_to_hue_chk.sv
`timescale 1ns / 1ps

// Watches both stream channels of the converter, works out the hue of every
// accepted pixel and compares each result request with the oldest hue due.
module rgb_to_hue_chk
    import rth_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [15:0] i_m_axis_tdata,   // [14:0] hue, [15] zero
    output int          o_pending,
    output int          o_fail_count
);

    logic [HUE_W-1:0] hue_due_q[$];

    // Hue in 1/64 degree. The channel holding the maximum picks the sector,
    // red winning ties over green and blue, and green winning over blue.
    function automatic logic [HUE_W-1:0] hue_of_pixel(input logic [CHAN_W-1:0] r,
                                                      input logic [CHAN_W-1:0] g,
                                                      input logic [CHAN_W-1:0] b);
        int         hi;
        int         lo;
        int         delta;
        int         num;
        int         angle;
        logic [1:0] sec;
        hi = int'(r);
        if (int'(g) > hi) hi = int'(g);
        if (int'(b) > hi) hi = int'(b);
        lo = int'(r);
        if (int'(g) < lo) lo = int'(g);
        if (int'(b) < lo) lo = int'(b);
        delta = hi - lo;
        if (delta == 0) begin
            return '0;
        end
        if (hi == int'(r)) begin
            sec = SEC_RED;
            num = int'(g) - int'(b);
        end else if (hi == int'(g)) begin
            sec = SEC_GREEN;
            num = int'(b) - int'(r);
        end else begin
            sec = SEC_BLUE;
            num = int'(r) - int'(g);
        end
        // Each sector spans 120 degrees; signed int division truncates toward zero.
        angle = int'(sec) * 2 * int'(HUE_SIXTY) + (num * int'(HUE_SIXTY)) / delta;
        if (angle < 0) begin
            angle = angle + int'(HUE_FULL);
        end
        return angle[HUE_W-1:0];
    endfunction

    // Both counts start at zero, as every int does.
    always @(posedge i_clk) begin
        logic [HUE_W-1:0] want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                hue_due_q.push_back(hue_of_pixel(i_s_axis_tdata[7:0],
                                                 i_s_axis_tdata[15:8],
                                                 i_s_axis_tdata[23:16]));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (hue_due_q.size() == 0) begin
                    $error("hue: expected none, actual %0d", i_m_axis_tdata[14:0]);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = hue_due_q.pop_front();
                    if (i_m_axis_tdata[14:0] !== want) begin
                        $error("hue: expected %0d, actual %0d", want,
                               i_m_axis_tdata[14:0]);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_m_axis_tdata[15] !== 1'b0) begin
                        $error("pad: expected 0, actual %b", i_m_axis_tdata[15]);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            o_pending = hue_due_q.size();
        end
    end

endmodule

>>> bench/rgb_to_hue_tb.sv
`timescale 1ns / 1ps

// Testbench top for the RGB to hue converter. It makes pixel requests on the
// slave stream and back-pressure on the master stream; the checker beside the
// block predicts every hue and counts failures, and this module gives the
// verdict once every expected hue has come back.
module rgb_to_hue_tb;
    import rth_pkg::*;

    localparam int RANDOM_PER_PHASE = 500;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = '0;   // [7:0] red, [15:8] green, [23:16] blue
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;        // [14:0] hue, [15] zero

    int pending;
    int fail_count;

    // Chance, in percent, that the sender leaves a cycle empty or the
    // receiver holds off a result in any given cycle.
    int sender_gap_pct = 16;
    int recv_stall_pct = 63;

    always #10 i_clk = ~i_clk;

    rgb_to_hue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    rgb_to_hue_chk chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .o_pending       (pending),
        .o_fail_count    (fail_count)
    );

    // The receiver decides afresh at every falling edge whether to take a result.
    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offers one pixel after a random number of empty cycles, and returns at
    // the falling edge after the request has been taken. The valid line stays
    // high between back-to-back pixels.
    task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b);
        while ($urandom_range(99) < sender_gap_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {b, g, r};
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // Picks one channel value, leaning on the extremes and their neighbours.
    function automatic logic [CHAN_W-1:0] pick_channel();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(3));
            3:       return 8'($urandom_range(255, 252));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Random pixels: most have distinct channels, a good share have ties for
    // the maximum or the minimum, and some are gray.
    task automatic send_random_pixels(input int count);
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        for (int n = 0; n < count; n++) begin
            r = pick_channel();
            g = pick_channel();
            b = pick_channel();
            case ($urandom_range(9))
                0:       begin g = r; b = r; end
                1:       g = r;
                2:       b = r;
                3:       b = g;
                default: ;
            endcase
            send_pixel(r, g, b);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed pixels: gray at both ends, the pure primaries, every tie
        // for the maximum, a red maximum whose quotient is zero, negative
        // hues that wrap round, and alternating bit patterns.
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd200, 8'd50,  8'd50);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd255, 8'd0,   8'd255 - 8'd1);
        send_pixel(8'd100, 8'd200, 8'd50);
        send_pixel(8'd10,  8'd20,  8'd200);
        send_pixel(8'd20,  8'd10,  8'd200);
        send_pixel(8'd128, 8'd128, 8'd127);
        send_pixel(8'hAA,  8'h55,  8'h0F);
        send_pixel(8'h55,  8'hAA,  8'hF0);
        send_pixel(8'h0F,  8'hF0,  8'hAA);

        send_random_pixels(RANDOM_PER_PHASE);

        // Let the pipeline drain completely before the next pixel is offered.
        i_s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);

        sender_gap_pct = 63;
        recv_stall_pct = 16;
        send_random_pixels(RANDOM_PER_PHASE);

        sender_gap_pct = 0;
        recv_stall_pct = 0;
        send_random_pixels(RANDOM_PER_PHASE);
        i_s_axis_tvalid = 1'b0;

        // Wait for every hue to come back, then wait longer than a pixel takes to
        // pass through the pipeline, so that any stray result shows.
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Safety net against a hung handshake.
    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
